### src/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants of the prime filter with saturating group sum
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int SUM_BITS = 41;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture a new item, divisor 3, square 9
        logic div_start;    // begin a remainder pass with the current divisor
        logic div_step;     // one restoring step of the remainder
        logic advance;      // next odd divisor and its square
        logic set_verdict;  // store the prime flag
        logic verdict;
        logic emit;         // update the sum and load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lt2;
        logic lt4;
        logic even;
        logic sq_gt_v;      // divisor squared exceeds the value
        logic div_done;
        logic rem_zero;
    } status_t;

endpackage

### src/pfs_ctrl.sv
// ----------------------------------------------------------------------------
// pfs_ctrl
// sequencer of the trial division and the output handshake
// ----------------------------------------------------------------------------
module pfs_ctrl
    import pfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.lt2 || (st.even && !st.lt4))
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    state_next      = S_FINISH;
                end
                else if (st.lt4 || st.sq_gt_v)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!st.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (st.rem_zero)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/pfs_dp.sv
// ----------------------------------------------------------------------------
// pfs_dp
// divisor and square tracking, bit-serial remainder, saturating group sum
// ----------------------------------------------------------------------------
module pfs_dp
    import pfs_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    input  cmd_t                  cmd,
    output status_t               st,
    output logic                  is_prime,
    output logic [SUM_BITS-1:0]   running_sum,
    output logic                  group_end
);

    localparam int SQ_W  = VALUE_BITS + 2;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int ACC_W = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  last_reg;
    logic [VALUE_BITS-1:0] d_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [VALUE_BITS-1:0] q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  verdict_reg;
    logic [SUM_BITS-1:0]   total_reg;
    logic [SUM_BITS-1:0]   total_new;
    logic [SUM_BITS-1:0]   sum_reg;
    logic                  prime_reg;
    logic                  end_reg;
    logic [VALUE_BITS:0]   trial;
    logic [ACC_W-1:0]      acc;

    // restoring step: bring in the next value bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, q_reg[VALUE_BITS-1]};
        if (trial >= {1'b0, d_reg})
            rem_next = VALUE_BITS'(trial - {1'b0, d_reg});
        else
            rem_next = trial[VALUE_BITS-1:0];
    end

    always_comb
    begin
        acc = ACC_W'(total_reg) + ACC_W'(value_reg);
        if (!verdict_reg)
            total_new = total_reg;
        else if (acc >= ACC_W'(SUM_MAX))
            total_new = SUM_MAX;
        else
            total_new = acc[SUM_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last;
            d_reg     <= VALUE_BITS'(3);
            sq_reg    <= SQ_W'(9);
        end
        if (cmd.advance)
        begin
            d_reg  <= d_reg + VALUE_BITS'(2);
            sq_reg <= sq_reg + (SQ_W'(d_reg) << 2) + SQ_W'(4);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            q_reg   <= value_reg;
            cnt_reg <= CNT_W'(VALUE_BITS);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_reg << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.set_verdict)
            verdict_reg <= cmd.verdict;
        if (cmd.emit)
        begin
            prime_reg <= verdict_reg;
            sum_reg   <= total_new;
            end_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cmd.emit)
            total_reg <= last_reg ? '0 : total_new;
    end

    always_comb
    begin
        st.lt2      = (value_reg < VALUE_BITS'(2));
        st.lt4      = (value_reg < VALUE_BITS'(4));
        st.even     = !value_reg[0];
        st.sq_gt_v  = (sq_reg > SQ_W'(value_reg));
        st.div_done = (cnt_reg == '0);
        st.rem_zero = (rem_reg == '0);
    end

    assign is_prime    = prime_reg;
    assign running_sum = sum_reg;
    assign group_end   = end_reg;

endmodule

### src/prime_filter_sum.sv
// ----------------------------------------------------------------------------
// prime_filter_sum
// trial-division prime test with a saturating per-group sum of the primes
// ----------------------------------------------------------------------------
// Each item carries a value and a last mark and yields exactly one result:
// is_prime, running_sum (the saturating 41-bit total of the primes seen in
// the group so far, this item included) and group_end (copy of last; the sum
// is cleared after such an item). Values below two are not prime, two and
// three are prime, even values above three are rejected at once. Odd values
// are tested with odd divisors d = 3, 5, 7, ... while d*d <= value; the square
// is kept up to date by adding 4d+4 per divisor, and each remainder comes
// from a bit-serial restoring unit, one value bit per step. One item is in
// work at a time; a 31-bit prime near the top of the range walks through
// about 23170 odd divisors. The result sits in an output register, so the
// next item is taken as soon as a result has been loaded, even while that
// result still waits for out_ready.
// ----------------------------------------------------------------------------
module prime_filter_sum
    import pfs_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    // result item channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_prime,
    output logic [SUM_BITS-1:0]   running_sum,
    output logic                  group_end
);

    cmd_t    cmd;
    status_t st;

    // sequencer: early cases, divisor loop, output handshake
    pfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: divisor, square, remainder unit, group total, output register
    pfs_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .last        (last),
        .cmd         (cmd),
        .st          (st),
        .is_prime    (is_prime),
        .running_sum (running_sum),
        .group_end   (group_end)
    );

endmodule

### src/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_assertions
// port-level checks of the prime filter, bound to the top level
// ----------------------------------------------------------------------------
module pfs_assertions
    import pfs_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [VALUE_BITS-1:0] value,
    input logic                  last,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  is_prime,
    input logic [SUM_BITS-1:0]   running_sum,
    input logic                  group_end
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(running_sum)
            && $stable(is_prime) && $stable(group_end))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is in work");

    // a new result is loaded only as the block frees its input
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while an item is still in work");

    // a value below two still goes through the sequencer like any other item
    a_small: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (value < VALUE_BITS'(2)) |=> !in_ready)
        else $error("small value handling broke the sequencing");

endmodule

bind prime_filter_sum pfs_assertions #(
    .VALUE_BITS (VALUE_BITS)
) u_pfs_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_prime    (is_prime),
    .running_sum (running_sum),
    .group_end   (group_end)
);

### bench/pfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfs_checker
// watches both item channels of prime_filter_sum, predicts and compares
// ----------------------------------------------------------------------------
// Every accepted input item is run through a trial-division primality test
// and a saturating group total kept here. The prediction is queued and each
// accepted result item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module pfs_checker
    import pfs_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  is_prime,
    input  logic [SUM_BITS-1:0]   running_sum,
    input  logic                  group_end,
    output int                    failures,
    output int                    pending
);

    typedef struct packed {
        logic                prime;
        logic [SUM_BITS-1:0] total;
        logic                group_end;
    } verdict_t;

    verdict_t            owed_verdicts[$];
    logic [SUM_BITS-1:0] group_total;

    // odd divisors only, while d*d <= n
    function automatic bit prime_by_division(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n % 2 == 0)
            return 1'b0;
        for (d = 3; d * d <= n; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        verdict_t made;
        if (!rst_n)
        begin
            owed_verdicts.delete();
            group_total = '0;
            pending     = 0;
        end
        else
        begin
            // a result can never belong to the item accepted at this edge
            if (out_valid && out_ready)
            begin
                if (owed_verdicts.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result: expected none, got is_prime %0d sum %0d end %0d",
                             $time, is_prime, running_sum, group_end);
                end
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (is_prime !== want.prime)
                    begin
                        failures++;
                        $display("%0t: is_prime: expected %0d, got %0d",
                                 $time, want.prime, is_prime);
                    end
                    if (running_sum !== want.total)
                    begin
                        failures++;
                        $display("%0t: running_sum: expected %0d, got %0d",
                                 $time, want.total, running_sum);
                    end
                    if (group_end !== want.group_end)
                    begin
                        failures++;
                        $display("%0t: group_end: expected %0d, got %0d",
                                 $time, want.group_end, group_end);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                made.prime = prime_by_division(longint'(value));
                if (made.prime)
                begin
                    if (SUM_BITS'(value) >= SUM_MAX - group_total)
                        group_total = SUM_MAX;
                    else
                        group_total = group_total + SUM_BITS'(value);
                end
                made.total     = group_total;
                made.group_end = last;
                owed_verdicts.push_back(made);
                if (last)
                    group_total = '0;
            end
            pending = owed_verdicts.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the prime filter with saturating group sum
// ----------------------------------------------------------------------------
// A directed run covers values below two, two and three, small squares of
// primes, even and odd values at the top of the range and the largest
// value, with groups closed by last. A random run follows, mostly small
// values with some large ones that have a small factor so they finish fast.
// Both sides idle in random bursts, the receiver holds off once for a long
// stretch, and the tail of the run goes at full rate. pfs_checker predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module tb_top
    import pfs_pkg::*;
;

    localparam int VALUE_BITS  = 31;
    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_CYCLES  = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  is_prime;
    logic [SUM_BITS-1:0]   running_sum;
    logic                  group_end;

    int failures;
    int pending;

    // gaps_on and items_sent are shared between the sender and the receiver; held_off is the receiver's own
    bit gaps_on = 1'b1;
    int items_sent = 0;
    bit held_off = 1'b0;

    always #5 clk = ~clk;

    prime_filter_sum #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_prime    (is_prime),
        .running_sum (running_sum),
        .group_end   (group_end)
    );

    pfs_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_prime    (is_prime),
        .running_sum (running_sum),
        .group_end   (group_end),
        .failures    (failures),
        .pending     (pending)
    );

    // offer one item at a falling edge, optionally after an idle burst,
    // and return at the falling edge after it was taken
    task automatic offer_number(input logic [VALUE_BITS-1:0] v, input logic l);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off so the block fills
    // up and pushes back on the sender, no stalls in the tail of the run
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && items_sent >= 40)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // sender and verdict
    initial
    begin : stimulus
        int unsigned r;
        int unsigned k;
        int unsigned f;
        logic [VALUE_BITS-1:0] v;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // below two never prime, two and three need no divisor, then four and five
        offer_number(31'd0, 1'b0);
        offer_number(31'd1, 1'b0);
        offer_number(31'd2, 1'b0);
        offer_number(31'd3, 1'b0);
        offer_number(31'd4, 1'b0);
        offer_number(31'd5, 1'b1);
        // squares of primes sit right on the d*d <= n bound, then 15 and 97
        offer_number(31'd9, 1'b0);
        offer_number(31'd25, 1'b0);
        offer_number(31'd49, 1'b0);
        offer_number(31'd961, 1'b0);
        offer_number(31'd15, 1'b0);
        offer_number(31'd97, 1'b1);
        // one-item groups, prime and not prime
        offer_number(31'd1, 1'b1);
        offer_number(31'd2, 1'b1);
        // top of the range and below: even values, odd with factor three, the prime 65537
        // and the maximum, which is prime and walks through every odd divisor
        offer_number(31'h7fff_fffe, 1'b0);
        offer_number(31'h3fff_ffff, 1'b0);
        offer_number(31'h4000_0000, 1'b0);
        offer_number(31'd65537, 1'b0);
        offer_number(31'h7fff_ffff, 1'b0);
        offer_number(31'd3, 1'b1);

        // random groups, mostly cheap values
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - 20)
                gaps_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 45)
                v = VALUE_BITS'($urandom_range(0, 4095));
            else if (r < 60)
                v = VALUE_BITS'($urandom_range(4096, 262143));
            else if (r < 80)
            begin
                // even values across the whole width
                v = VALUE_BITS'($urandom);
                v[0] = 1'b0;
            end
            else
            begin
                // odd values across the whole width, rejected at a small divisor unless k is one
                case ($urandom_range(0, 2))
                    0: f = 3;
                    1: f = 5;
                    default: f = 7;
                endcase
                k = $urandom_range(1, 32'h7fff_ffff / f - 1) | 1;
                v = VALUE_BITS'(k * f);
            end
            offer_number(v, (i == RANDOM_ITEMS - 1) || ($urandom_range(0, 4) == 0));
        end
        in_valid <= 1'b0;

        // drain, then a short quiet stretch to catch stray results
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // generous bound on the whole run, the largest prime included
    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
